/* rtl/core/sif_pkg.sv */
// Shared types and constants for the set intersection filter.
`default_nettype none

package sif_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_LATER  = 2'd1,
    MODE_CLOSE  = 2'd2,
    MODE_REPORT = 2'd3
  } mode_t;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned REPORT_MAX = 64;

  // Output tuser bit positions.
  localparam int unsigned FLAG_NONE = 0;
  localparam int unsigned FLAG_OVF  = 1;

endpackage

`default_nettype wire

/* rtl/core/set_intersection_filter_unit.sv */
// Set intersection filter: candidate store, shared compare scan and report sequencer.
//
//   port group | dir | tdata            | tuser                       | tlast
//   in_*       | in  | value            | mode                        | -
//   out_*      | out | common_value     | none_common, overflowed     | last_of_report
//
// First and later elements and close items hold in_tready low while the store is scanned:
// one store word is read per cycle and checked by the one 32-bit comparator; a first
// element that hits a duplicate leaves early. A report reads each result in ST_REP_RD and
// loads it to the output in ST_REP_LD, where it waits while the output stalls.
// rst_n (synchronous) empties the set and clears the overflow flag; no clearing pass.
`default_nettype none

module set_intersection_filter_unit #(
  parameter int unsigned MAX_SET = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] common_value
  output logic             out_tlast,
  output logic [1:0]       out_tuser   // [0] none_common, [1] overflowed
);

  localparam int unsigned AW = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
  localparam int unsigned CW = $clog2(MAX_SET + 1);
  localparam int unsigned DW = sif_pkg::VALUE_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SET);
  localparam logic [CW-1:0] RPT_N =
    (MAX_SET < sif_pkg::REPORT_MAX) ? CW'(MAX_SET) : CW'(sif_pkg::REPORT_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REP_RD,
    ST_REP_LD
  } state_t;

  // Store word: mark in the top bit, value below.
  logic [DW:0] mem [0:MAX_SET-1];
  logic [DW:0] rd_data_r;

  state_t              state_r, state_nxt;
  sif_pkg::mode_t      op_r, op_nxt;
  logic [DW-1:0]       val_r, val_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       w_r, w_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [DW-1:0]       out_tdata_r, out_tdata_nxt;
  logic                out_tlast_r, out_tlast_nxt;
  logic [1:0]          out_tuser_r, out_tuser_nxt;

  logic                we_c;
  logic [AW-1:0]       wa_c;
  logic [DW:0]         wd_c;
  logic                hit_c;
  logic                scan_done_c;
  logic                out_free_c;
  logic [CW-1:0]       idx_inc_c;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  assign hit_c       = pend_r && (rd_data_r[DW-1:0] == val_r);
  assign scan_done_c = !pend_r && (idx_r == count_r);
  assign out_free_c  = !out_tvalid_r || out_tready;
  assign idx_inc_c   = idx_r + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_nxt       = pend_r;
    w_nxt          = w_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    out_tuser_nxt  = out_tuser_r;
    we_c           = 1'b0;
    wa_c           = cmp_idx_r;
    wd_c           = {1'b0, rd_data_r[DW-1:0]};

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = sif_pkg::mode_t'(in_tuser);
          val_nxt  = in_tdata;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          w_nxt    = '0;
          if (sif_pkg::mode_t'(in_tuser) == sif_pkg::MODE_REPORT) begin
            state_nxt = ST_REP_RD;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous word is compared.
        if (idx_r != count_r) begin
          idx_nxt     = idx_inc_c;
          cmp_idx_nxt = idx_r[AW-1:0];
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end

        case (op_r)
          sif_pkg::MODE_FIRST: begin
            if (hit_c) begin
              state_nxt = ST_IDLE;
            end else if (scan_done_c) begin
              if (count_r < MAX_C) begin
                we_c      = 1'b1;
                wa_c      = count_r[AW-1:0];
                wd_c      = {1'b0, val_r};
                count_nxt = count_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              state_nxt = ST_IDLE;
            end
          end
          sif_pkg::MODE_LATER: begin
            if (hit_c) begin
              we_c = 1'b1;
              wa_c = cmp_idx_r;
              wd_c = {1'b1, rd_data_r[DW-1:0]};
            end
            if (scan_done_c) begin
              state_nxt = ST_IDLE;
            end
          end
          sif_pkg::MODE_CLOSE: begin
            // Keep marked words, packed down in order, with the mark cleared.
            if (pend_r && rd_data_r[DW]) begin
              we_c  = 1'b1;
              wa_c  = w_r[AW-1:0];
              wd_c  = {1'b0, rd_data_r[DW-1:0]};
              w_nxt = w_r + CW'(1);
            end
            if (scan_done_c) begin
              count_nxt = w_r;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_REP_RD: begin
        state_nxt = ST_REP_LD;
      end

      ST_REP_LD: begin
        if (out_free_c) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt[sif_pkg::FLAG_OVF] = ovf_r;
          if (count_r == '0) begin
            out_tdata_nxt = '0;
            out_tlast_nxt = 1'b1;
            out_tuser_nxt[sif_pkg::FLAG_NONE] = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            out_tdata_nxt = rd_data_r[DW-1:0];
            out_tuser_nxt[sif_pkg::FLAG_NONE] = 1'b0;
            if ((idx_inc_c == count_r) || (idx_inc_c == RPT_N)) begin
              out_tlast_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              out_tlast_nxt = 1'b0;
              idx_nxt       = idx_inc_c;
              state_nxt     = ST_REP_RD;
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_r       <= 1'b0;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
      w_r          <= '0;
      op_r         <= sif_pkg::MODE_FIRST;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      idx_r        <= idx_nxt;
      w_r          <= w_nxt;
      op_r         <= op_nxt;
    end
    val_r       <= val_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // Candidate store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[wa_c] <= wd_c;
    end
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r[sif_pkg::FLAG_NONE]) |-> out_tlast_r)
    else $error("empty report word not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("set count beyond store depth");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && pend_r) |-> (CW'(cmp_idx_r) < count_r))
    else $error("compare on a word beyond the set");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_report_holds_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REP_LD || state_r == ST_REP_RD) |=> $stable(count_r))
    else $error("set count changed during report");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the set intersection filter unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_DEPTH   = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned END_PAUSE   = 200;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    sif_pkg::mode_t mode;
    logic [31:0]    value;
  } filter_item_t;

  typedef struct {
    logic [31:0] common_value;
    logic        last_flag;
    logic        none_flag;
    logic        ovf_flag;
  } common_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  // Own copy of the candidate store
  logic [31:0] cand_value [SET_DEPTH];
  bit          cand_mark  [SET_DEPTH];
  int unsigned set_size      = 0;
  bit          overflow_seen = 1'b0;

  filter_item_t pending_items [$];
  common_word_t expected_words [$];
  common_word_t next_word;
  logic [31:0]  job_vals [$];

  int unsigned total_items   = 0;
  int unsigned items_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned report_count  = 0;
  int unsigned empty_reports = 0;
  int unsigned longest_report = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  int unsigned tx_gap    = 0;
  int unsigned rx_stall  = 0;
  int unsigned calm_left = 0;
  bit          tx_calm   = 1'b0;
  bit          rx_calm   = 1'b0;
  logic        hold_off  = 1'b0;

  set_intersection_filter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Apply one accepted item to the predicted store and queue the words it yields.
  function automatic void intersect_step(sif_pkg::mode_t mode, logic [31:0] value);
    bit          hit;
    int unsigned keep;
    int unsigned n;
    common_word_t w;
    case (mode)
      sif_pkg::MODE_FIRST: begin
        hit = 1'b0;
        for (int i = 0; i < set_size; i++)
          if (cand_value[i] == value) hit = 1'b1;
        if (!hit) begin
          if (set_size < SET_DEPTH) begin
            cand_value[set_size] = value;
            cand_mark[set_size]  = 1'b0;
            set_size++;
          end else begin
            overflow_seen = 1'b1;
          end
        end
      end
      sif_pkg::MODE_LATER: begin
        for (int i = 0; i < set_size; i++)
          if (cand_value[i] == value) cand_mark[i] = 1'b1;
      end
      sif_pkg::MODE_CLOSE: begin
        keep = 0;
        for (int i = 0; i < set_size; i++) begin
          if (cand_mark[i]) begin
            cand_value[keep] = cand_value[i];
            keep++;
          end
        end
        for (int i = 0; i < SET_DEPTH; i++) cand_mark[i] = 1'b0;
        set_size = keep;
      end
      default: begin
        report_count++;
        w.ovf_flag = overflow_seen;
        if (set_size == 0) begin
          w.common_value = '0;
          w.last_flag    = 1'b1;
          w.none_flag    = 1'b1;
          expected_words.push_back(w);
          empty_reports++;
        end else begin
          n = (set_size < sif_pkg::REPORT_MAX) ? set_size : sif_pkg::REPORT_MAX;
          if (n > longest_report) longest_report = n;
          for (int i = 0; i < n; i++) begin
            w.common_value = cand_value[i];
            w.last_flag    = (i + 1 == n);
            w.none_flag    = 1'b0;
            expected_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  task automatic log_mismatch(string field, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch on %s at word %0d: got %h, want %h",
               field, words_checked, got, want);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 15)) - 32'd8;
      default: begin
        if (job_vals.size() != 0) return job_vals[$urandom_range(0, job_vals.size() - 1)];
        return 32'($urandom_range(0, 15));
      end
    endcase
  endfunction

  task automatic push_item(sif_pkg::mode_t mode, logic [31:0] value);
    filter_item_t it;
    it.mode  = mode;
    it.value = value;
    pending_items.push_back(it);
    total_items++;
  endtask

  // One well-formed job: a first array, some later arrays each closed, then a report.
  task automatic add_job();
    int unsigned n_later;
    logic [31:0] v;
    job_vals.delete();
    repeat ($urandom_range(1, 12)) begin
      v = pick_value();
      job_vals.push_back(v);
      push_item(sif_pkg::MODE_FIRST, v);
    end
    n_later = $urandom_range(0, 3);
    repeat (n_later) begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0: begin
            v = pick_value();
            job_vals.push_back(v);
            push_item(sif_pkg::MODE_FIRST, v);
          end
          1, 2: push_item(sif_pkg::MODE_LATER, $urandom);
          default: push_item(sif_pkg::MODE_LATER,
                             job_vals[$urandom_range(0, job_vals.size() - 1)]);
        endcase
      end
      if ($urandom_range(0, 4) == 0) push_item(sif_pkg::MODE_REPORT, $urandom);
      push_item(sif_pkg::MODE_CLOSE, $urandom);
    end
    push_item(sif_pkg::MODE_REPORT, $urandom);
  endtask

  // Stretches with and without idling on either side
  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm_left <= $urandom_range(30, 300);
      tx_calm   <= ($urandom_range(0, 3) == 0);
      rx_calm   <= ($urandom_range(0, 3) == 0);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else if (in_tvalid && !in_tready) begin
      // hold the word until taken
    end else if (tx_gap != 0) begin
      in_tvalid <= 1'b0;
      tx_gap    <= tx_gap - 1;
    end else if (pending_items.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_items[0].value;
      in_tuser  <= pending_items[0].mode;
      void'(pending_items.pop_front());
      tx_gap    <= tx_calm ? 0 : pick_gap();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else if (rx_stall != 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      rx_stall   <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          log_mismatch("unexpected result word", out_tdata, '0);
        end else begin
          next_word = expected_words.pop_front();
          if (out_tdata !== next_word.common_value)
            log_mismatch("common_value", out_tdata, next_word.common_value);
          if (out_tlast !== next_word.last_flag)
            log_mismatch("last_of_report", 32'(out_tlast), 32'(next_word.last_flag));
          if (out_tuser[sif_pkg::FLAG_NONE] !== next_word.none_flag)
            log_mismatch("none_common", 32'(out_tuser[sif_pkg::FLAG_NONE]),
                         32'(next_word.none_flag));
          if (out_tuser[sif_pkg::FLAG_OVF] !== next_word.ovf_flag)
            log_mismatch("overflowed", 32'(out_tuser[sif_pkg::FLAG_OVF]),
                         32'(next_word.ovf_flag));
        end
        words_checked++;
      end
      if (in_tvalid && in_tready) begin
        intersect_step(sif_pkg::mode_t'(in_tuser), in_tdata);
        items_taken++;
      end
    end
  end

  // Long receiver hold-off in the middle of a report, so the input backs up
  initial begin
    while (!(out_tvalid && words_checked >= 20)) @(negedge clk);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("status: fail");
    $finish;
  end

  initial begin
    // Directed: empty report, empty close, extremes, duplicates, late insert
    push_item(sif_pkg::MODE_REPORT, 32'hFFFF_FFFF);
    push_item(sif_pkg::MODE_CLOSE,  32'h0000_0000);
    push_item(sif_pkg::MODE_FIRST,  32'h7FFF_FFFF);
    push_item(sif_pkg::MODE_FIRST,  32'h8000_0000);
    push_item(sif_pkg::MODE_FIRST,  32'h0000_0000);
    push_item(sif_pkg::MODE_FIRST,  32'hFFFF_FFFF);
    push_item(sif_pkg::MODE_FIRST,  32'h7FFF_FFFF);
    push_item(sif_pkg::MODE_FIRST,  32'h0000_0001);
    push_item(sif_pkg::MODE_REPORT, 32'h0000_0000);
    push_item(sif_pkg::MODE_LATER,  32'h8000_0000);
    push_item(sif_pkg::MODE_LATER,  32'hFFFF_FFFF);
    push_item(sif_pkg::MODE_LATER,  32'h0001_2345);
    push_item(sif_pkg::MODE_LATER,  32'h8000_0000);
    push_item(sif_pkg::MODE_FIRST,  32'h5555_5555);
    push_item(sif_pkg::MODE_FIRST,  32'hAAAA_AAAA);
    push_item(sif_pkg::MODE_LATER,  32'h5555_5555);
    push_item(sif_pkg::MODE_CLOSE,  32'hFFFF_FFFF);
    push_item(sif_pkg::MODE_REPORT, 32'h5555_5555);
    push_item(sif_pkg::MODE_CLOSE,  32'hAAAA_AAAA);
    push_item(sif_pkg::MODE_REPORT, 32'h0000_0000);

    // Random jobs with the odd burst of arbitrary words
    while (total_items < 140) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(3, 10))
          push_item(sif_pkg::mode_t'($urandom_range(0, 3)), pick_value());
      end else begin
        add_job();
      end
    end

    // Overfill the store: distinct top bytes, a few repeats, then a full report
    job_vals.delete();
    for (int i = 0; i < 68; i++) begin
      job_vals.push_back({8'(i), 24'($urandom)});
      push_item(sif_pkg::MODE_FIRST, job_vals[i]);
      if (i % 10 == 9) push_item(sif_pkg::MODE_FIRST, job_vals[$urandom_range(0, i)]);
    end
    push_item(sif_pkg::MODE_REPORT, $urandom);
    repeat (15) push_item(sif_pkg::MODE_LATER, job_vals[$urandom_range(0, 67)]);
    push_item(sif_pkg::MODE_CLOSE, $urandom);
    push_item(sif_pkg::MODE_REPORT, $urandom);
    repeat (2) add_job();

    while (pending_items.size() != 0 || in_tvalid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (END_PAUSE) @(negedge clk);

    $display("run: %0d items accepted, %0d result words checked over %0d reports",
             items_taken, words_checked, report_count);
    $display("run: %0d empty reports, longest report %0d words, overflow reached: %0d",
             empty_reports, longest_report, overflow_seen);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
